// ===== hw/rtl/perw_pkg.sv =====
// Package for the packet error rate window block.
// Widths, constants and the structs passed between the window and divider.
// No dependencies.
`timescale 1ns / 1ps

package perw_pkg;

  localparam int SEQ_BITS   = 12;
  localparam int CNT_W      = 13;
  localparam int PER_W      = 14;
  localparam int DVD_W      = 27;                 // holds 8191 * 10000
  localparam int STEP_W     = $clog2(DVD_W);

  localparam logic [CNT_W-1:0]    COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [PER_W-1:0]    FULL_SCALE = PER_W'(10000);
  localparam logic [SEQ_BITS-1:0] RESET_SPAN = SEQ_BITS'(100);
  localparam logic [STEP_W-1:0]   LAST_STEP  = STEP_W'(DVD_W - 1);

  // window close request to the divider
  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic [SEQ_BITS-1:0] span;
  } win_req_t;

  // finished measurement
  typedef struct packed {
    logic [PER_W-1:0]    per;
    logic [SEQ_BITS-1:0] span;
    logic [CNT_W-1:0]    count;
    logic                over;
  } win_res_t;

endpackage

// ===== hw/rtl/packet_error_rate_window.sv =====
// Top level of the packet error rate window block.
// Instantiates perw_window and perw_div, holds the output register. Uses perw_pkg.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_seq_num
//   out_     output     out_valid/out_stall  per_hundredths, span_used, received, over
//   cfg_     input      cfg_wr_en            cfg_wr_data (window span)
//
// A request that does not close a window is taken at once while the divider is idle.
// One closing it starts the 27-step serial divider; in_ stalls till the result is taken.
// Synchronous active-low reset: window 100, start 0, count 0, output empty.
// A stalled result holds in the output register; the divider waits behind it
// and in_stall stays high while the divider is busy or holding.
`timescale 1ns / 1ps

module packet_error_rate_window (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_seq_num,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_per_hundredths,
  output logic [11:0] out_span_used,
  output logic [12:0] out_received_in_window,
  output logic        out_over_count,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data
);

  logic                accept;
  logic                req_valid;
  perw_pkg::win_req_t  req;
  logic                div_busy;
  logic                res_valid;
  logic                res_take;
  perw_pkg::win_res_t  res;
  logic                out_valid_r, out_valid_nxt;
  perw_pkg::win_res_t  out_r;

  assign in_stall = div_busy;
  assign accept   = in_valid && !in_stall;

  perw_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .seq_num     (in_seq_num),
    .req_valid   (req_valid),
    .req         (req)
  );

  perw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (req_valid),
    .req       (req),
    .res_take  (res_take),
    .busy      (div_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_per_hundredths     = out_r.per;
  assign out_span_used          = out_r.span;
  assign out_received_in_window = out_r.count;
  assign out_over_count         = out_r.over;

  a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |=> div_busy)
    else $error("divider not busy after window close");

  a_hold_result : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("divider result lost while output full");

  a_per_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_per_hundredths <= 14'd10000)
    else $error("rate above full scale");

  a_over_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_over_count |-> out_per_hundredths == 14'd0)
    else $error("clamped rate not zero");

endmodule

// ===== hw/rtl/perw_window.sv =====
// Window tracker: window register, window start and received count.
// Raises a close request when the span reaches the window. Uses perw_pkg.
`timescale 1ns / 1ps

module perw_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [perw_pkg::SEQ_BITS-1:0]   cfg_wr_data,
  input  logic                            accept,
  input  logic [perw_pkg::SEQ_BITS-1:0]   seq_num,
  output logic                            req_valid,
  output perw_pkg::win_req_t              req
);

  logic [perw_pkg::SEQ_BITS-1:0] win_span_r;
  logic [perw_pkg::SEQ_BITS-1:0] start_r, start_nxt;
  logic [perw_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [perw_pkg::SEQ_BITS-1:0] next_pos;
  logic [perw_pkg::SEQ_BITS-1:0] span;
  logic [perw_pkg::SEQ_BITS-1:0] win;
  logic [perw_pkg::CNT_W-1:0]    count_inc;
  logic                          close;

  always_comb begin
    next_pos  = seq_num + perw_pkg::SEQ_BITS'(1);
    span      = next_pos - start_r;
    win       = (win_span_r == '0) ? perw_pkg::SEQ_BITS'(1) : win_span_r;
    count_inc = (count_r == perw_pkg::COUNT_MAX) ? count_r
                                                 : count_r + perw_pkg::CNT_W'(1);
    close     = (span >= win);
    start_nxt = start_r;
    count_nxt = count_r;
    if (accept) begin
      if (close) begin
        start_nxt = next_pos;
        count_nxt = '0;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  assign req_valid = accept && close;
  assign req.count = count_inc;
  assign req.span  = span;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_span_r <= perw_pkg::RESET_SPAN;
      start_r    <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_span_r <= cfg_wr_data;
      end
      start_r <= start_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/perw_div.sv =====
// Bit-serial restoring divider: count*10000 / span, one quotient bit a cycle.
// Holds the result until the output register takes it. Uses perw_pkg.
`timescale 1ns / 1ps

module perw_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  perw_pkg::win_req_t   req,
  input  logic                 res_take,
  output logic                 busy,
  output logic                 res_valid,
  output perw_pkg::win_res_t   res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [perw_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [perw_pkg::SEQ_BITS-1:0] rem_r, rem_nxt;
  logic [perw_pkg::DVD_W-1:0]    dq_r, dq_nxt;
  logic [perw_pkg::SEQ_BITS-1:0] dvs_r;
  logic [perw_pkg::CNT_W-1:0]    cnt_r;
  logic [perw_pkg::SEQ_BITS:0]   trial;
  logic [perw_pkg::SEQ_BITS:0]   diff;
  logic                          ge;
  logic                          over;

  always_comb begin
    trial = {rem_r, dq_r[perw_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          step_nxt  = perw_pkg::LAST_STEP;
          rem_nxt   = '0;
          dq_nxt    = perw_pkg::DVD_W'(req.count) * perw_pkg::DVD_W'(perw_pkg::FULL_SCALE);
        end
      end
      ST_RUN: begin
        rem_nxt  = ge ? diff[perw_pkg::SEQ_BITS-1:0] : trial[perw_pkg::SEQ_BITS-1:0];
        dq_nxt   = {dq_r[perw_pkg::DVD_W-2:0], ge};
        step_nxt = step_r - perw_pkg::STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dq_r   <= dq_nxt;
    if (state_r == ST_IDLE && start) begin
      dvs_r <= req.span;
      cnt_r <= req.count;
    end
  end

  assign over      = (dq_r > perw_pkg::DVD_W'(perw_pkg::FULL_SCALE));
  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res.per   = over ? '0 : perw_pkg::FULL_SCALE - dq_r[perw_pkg::PER_W-1:0];
  assign res.span  = dvs_r;
  assign res.count = cnt_r;
  assign res.over  = over;

endmodule
